/* sv/udf_pkg.sv */
// ----------------------------------------------------------------------------
// udf_pkg
// Shared types and constants for the unsigned decimal formatter.
// ----------------------------------------------------------------------------
package udf_pkg;

   // fixed field widths
   localparam int VALUE_W    = 32;
   localparam int LEN_IN_W   = 7;
   localparam int CHAR_W     = 6;

   // decimal digits of a 32-bit value and the width of their count
   localparam int NUM_DIGITS = 10;
   localparam int DIG_CNT_W  = 4;
   localparam int BCD_W      = 4 * NUM_DIGITS;

   // ASCII characters, trimmed to the character field
   localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

   // top-level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LOAD,
      ST_EMIT
   } state_type;

endpackage

/* sv/udf_req_if.sv */
// ----------------------------------------------------------------------------
// udf_req_if
// Request channel: one value and its conversion spec per word.
// ----------------------------------------------------------------------------
interface udf_req_if;
   logic                            valid;
   logic                            ready;
   logic [udf_pkg::VALUE_W-1:0]     value;
   logic                            prec_enable;
   logic [udf_pkg::LEN_IN_W-1:0]    prec_len;
   logic                            zero_pad;
   logic                            left_justify;
   logic [udf_pkg::LEN_IN_W-1:0]    field_width;

   modport source (
      output valid, value, prec_enable, prec_len, zero_pad, left_justify, field_width,
      input  ready
   );

   modport sink (
      input  valid, value, prec_enable, prec_len, zero_pad, left_justify, field_width,
      output ready
   );
endinterface

/* sv/udf_rsp_if.sv */
// ----------------------------------------------------------------------------
// udf_rsp_if
// Response channel: one ASCII character per word, last marks the end.
// ----------------------------------------------------------------------------
interface udf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [udf_pkg::CHAR_W-1:0]    out_char;
   logic                          last;

   modport source (
      output valid, out_char, last,
      input  ready
   );

   modport sink (
      input  valid, out_char, last,
      output ready
   );
endinterface

/* sv/udf_bin2bcd.sv */
// ----------------------------------------------------------------------------
// udf_bin2bcd
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module udf_bin2bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [udf_pkg::VALUE_W-1:0]   value,
   output logic                          busy,
   output logic [udf_pkg::BCD_W-1:0]     bcd
);
   import udf_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W + 1);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BCD_W-1:0]   adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   // load on start, shift one bit in per cycle until the count runs out
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      if (start) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = CNT_W'(VALUE_W);
      end else if (count_ff != '0) begin
         bin_in   = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy = (count_ff != '0);
   assign bcd  = bcd_ff;

endmodule

/* sv/udf_emitter.sv */
// ----------------------------------------------------------------------------
// udf_emitter
// Character sequencer: leading spaces, zeros, digits, trailing spaces,
// one word per cycle unless stalled, through a registered response stage.
// ----------------------------------------------------------------------------
module udf_emitter #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      lead_cnt,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      zero_cnt,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      dig_cnt,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      trail_cnt,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      total_cnt,
   input  logic [udf_pkg::BCD_W-1:0]           digits,
   output logic                                busy,
   udf_rsp_if.source                           rsp_ch
);
   import udf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0]     lead_ff, lead_in;
   logic [CW-1:0]     zero_ff, zero_in;
   logic [CW-1:0]     dig_ff, dig_in;
   logic [CW-1:0]     trail_ff, trail_in;
   logic [CW-1:0]     total_ff, total_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              step;
   logic [CHAR_W-1:0] next_char;
   logic [DIG_CNT_W-1:0] skip;

   // a character moves out when there is one left and the output stage is free
   assign step = (total_ff != '0) && (!valid_ff || rsp_ch.ready);

   // the digit count never exceeds NUM_DIGITS, so its low bits are enough
   assign skip = DIG_CNT_W'(NUM_DIGITS) - dig_cnt[DIG_CNT_W-1:0];

   // pick the character from the first section that still has some left
   always_comb begin
      if (lead_ff != '0) begin
         next_char = CH_SPACE;
      end else if (zero_ff != '0) begin
         next_char = CH_ZERO;
      end else if (dig_ff != '0) begin
         next_char = CH_ZERO + CHAR_W'(bcd_ff[BCD_W-1 -: 4]);
      end else begin
         next_char = CH_SPACE;
      end
   end

   // load counts, align digits to the top, then count sections down
   always_comb begin
      lead_in  = lead_ff;
      zero_in  = zero_ff;
      dig_in   = dig_ff;
      trail_in = trail_ff;
      total_in = total_ff;
      bcd_in   = bcd_ff;
      if (load) begin
         lead_in  = lead_cnt;
         zero_in  = zero_cnt;
         dig_in   = dig_cnt;
         trail_in = trail_cnt;
         total_in = total_cnt;
         bcd_in   = digits << {skip, 2'b00};
      end else if (step) begin
         total_in = total_ff - 1'b1;
         if (lead_ff != '0) begin
            lead_in = lead_ff - 1'b1;
         end else if (zero_ff != '0) begin
            zero_in = zero_ff - 1'b1;
         end else if (dig_ff != '0) begin
            dig_in = dig_ff - 1'b1;
            bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         end else begin
            trail_in = trail_ff - 1'b1;
         end
      end
   end

   // output stage: fill on a step, drop when the receiver takes the word
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (step) begin
         valid_in = 1'b1;
         char_in  = next_char;
         last_in  = (total_ff == CW'(1));
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         lead_ff  <= '0;
         zero_ff  <= '0;
         dig_ff   <= '0;
         trail_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         lead_ff  <= lead_in;
         zero_ff  <= zero_in;
         dig_ff   <= dig_in;
         trail_ff <= trail_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy            = (total_ff != '0);
   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_char = char_ff;
   assign rsp_ch.last     = last_ff;

endmodule

/* sv/unsigned_decimal_formatter.sv */
// ----------------------------------------------------------------------------
// unsigned_decimal_formatter
// printf-style %u conversion: a 32-bit value and its spec in, the formatted
// ASCII text out one character per word.
// ----------------------------------------------------------------------------
//   req_ch takes one value with precision, zero, minus and width flags per
//   word; rsp_ch returns the text one character per word, last set on the
//   final character. An empty text (precision 0 on value 0, no width)
//   returns no words at all.
//   Timing per value with N characters (N up to MAX_WIDTH): bit-serial BCD
//   conversion (one shift per bit, then a check that it has finished), the
//   ST_LOAD state to size the padding, then one character per cycle into
//   the output register while the receiver keeps up. The serial converter
//   and the sequencer set the time per value. A stalled receiver holds the
//   output register and pauses the sequencer; the next value is taken once
//   the block is back in idle after the last character has entered the
//   output register. Reset (synchronous, active high) empties the output
//   register and returns the block to idle at once.
// ----------------------------------------------------------------------------
module unsigned_decimal_formatter #(
   parameter int MAX_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   udf_req_if.sink     req_ch,
   udf_rsp_if.source   rsp_ch
);
   import udf_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int SAT_W = (CW > LEN_IN_W) ? CW : LEN_IN_W;

   state_type state_ff, state_in;

   logic [CW-1:0]      prec_ff, prec_in;
   logic [CW-1:0]      width_ff, width_in;
   logic               pen_ff, pen_in;
   logic               zf_ff, zf_in;
   logic               lj_ff, lj_in;
   logic               zero_val_ff, zero_val_in;

   logic               accept;
   logic               conv_busy;
   logic [BCD_W-1:0]   bcd;
   logic               emit_busy;
   logic               load;

   logic [DIG_CNT_W-1:0] hi_digit;
   logic [CW-1:0]      nd;
   logic [CW-1:0]      lead_cnt, zero_cnt, trail_cnt, total_cnt;

   assign accept = req_ch.valid && req_ch.ready;

   // capture the spec, saturating the lengths to MAX_WIDTH
   always_comb begin
      prec_in     = prec_ff;
      width_in    = width_ff;
      pen_in      = pen_ff;
      zf_in       = zf_ff;
      lj_in       = lj_ff;
      zero_val_in = zero_val_ff;
      if (accept) begin
         if (SAT_W'(req_ch.prec_len) > SAT_W'(MAX_WIDTH)) begin
            prec_in = CW'(MAX_WIDTH);
         end else begin
            prec_in = CW'(req_ch.prec_len);
         end
         if (SAT_W'(req_ch.field_width) > SAT_W'(MAX_WIDTH)) begin
            width_in = CW'(MAX_WIDTH);
         end else begin
            width_in = CW'(req_ch.field_width);
         end
         pen_in      = req_ch.prec_enable;
         zf_in       = req_ch.zero_pad;
         lj_in       = req_ch.left_justify;
         zero_val_in = (req_ch.value == '0);
      end
   end

   always_ff @(posedge clock) begin
      prec_ff     <= prec_in;
      width_ff    <= width_in;
      pen_ff      <= pen_in;
      zf_ff       <= zf_in;
      lj_ff       <= lj_in;
      zero_val_ff <= zero_val_in;
   end

   udf_bin2bcd u_bin2bcd (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_ch.value),
      .busy  (conv_busy),
      .bcd   (bcd)
   );

   // digit count: highest non-zero digit, at least one, none when empty
   always_comb begin
      hi_digit = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (bcd[4*k +: 4] != 4'd0) begin
            hi_digit = DIG_CNT_W'(k + 1);
         end
      end
      if (pen_ff && (prec_ff == '0) && zero_val_ff) begin
         nd = '0;
      end else if (hi_digit == '0) begin
         nd = CW'(1);
      end else begin
         nd = CW'(hi_digit);
      end
   end

   // size the padding sections in priority order
   always_comb begin
      lead_cnt  = '0;
      zero_cnt  = '0;
      trail_cnt = '0;
      if (pen_ff && (prec_ff > nd)) begin
         zero_cnt = prec_ff - nd;
         if (width_ff > prec_ff) begin
            if (lj_ff) begin
               trail_cnt = width_ff - prec_ff;
            end else begin
               lead_cnt = width_ff - prec_ff;
            end
         end
      end else if (zf_ff && (width_ff > nd)) begin
         zero_cnt = width_ff - nd;
      end else if (lj_ff && (width_ff > nd)) begin
         trail_cnt = width_ff - nd;
      end else if (width_ff > nd) begin
         lead_cnt = width_ff - nd;
      end
      total_cnt = lead_cnt + zero_cnt + nd + trail_cnt;
   end

   // sequence: accept, convert, size, emit
   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (!conv_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            load     = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   udf_emitter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .lead_cnt  (lead_cnt),
      .zero_cnt  (zero_cnt),
      .dig_cnt   (nd),
      .trail_cnt (trail_cnt),
      .total_cnt (total_cnt),
      .digits    (bcd),
      .busy      (emit_busy),
      .rsp_ch    (rsp_ch)
   );

endmodule
